FILE: rtl/tvpsg_pkg.sv
// Shared types and constants for the three-voice tone/noise/envelope sound generator.
// Used by tvpsg_regs, tvpsg_gen and the top level.
package tvpsg_pkg;

  localparam int unsigned PRESCALE_DEF = 16;
  localparam int unsigned NUM_REGS     = 16;
  localparam int unsigned NUM_VOICES   = 3;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2
  } opcode_e;

  localparam logic [3:0] REG_NOISE_PER  = 4'd6;
  localparam logic [3:0] REG_MIXER      = 4'd7;
  localparam logic [3:0] REG_AMP_A      = 4'd8;
  localparam logic [3:0] REG_ENV_FINE   = 4'd11;
  localparam logic [3:0] REG_ENV_COARSE = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE  = 4'd13;

  localparam logic CFG_CYCLES_PER_SAMPLE = 1'b0;

  typedef logic [NUM_REGS-1:0][7:0] reg_file_t;

  typedef struct packed {
    logic       advance;
    logic       shape_wr;
    logic [3:0] shape;
  } gen_ctrl_t;

  typedef struct packed {
    logic [NUM_VOICES-1:0] tone_sign;
    logic                  noise_bit;
    logic [3:0]            env_level;
  } gen_out_t;

endpackage

FILE: rtl/three_voice_tone_noise_envelope_psg_unit.sv
// Three-voice tone/noise/envelope sound generator, top level.
// An item goes through the input register, then its result into the result register.
// Throughput: one item per cycle unless stalled; each register holds one item.
// Reset: all sound registers, counters and envelope state clear, noise register to 1,
// cycles_per_sample to 1. Depends on tvpsg_pkg, tvpsg_regs and tvpsg_gen.
module three_voice_tone_noise_envelope_psg_unit #(
  parameter int unsigned PRESCALE = tvpsg_pkg::PRESCALE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [3:0]  reg_addr_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic        sample_valid_o,
  output logic [3:0]  level_a_o,
  output logic [3:0]  level_b_o,
  output logic [3:0]  level_c_o
);
  import tvpsg_pkg::*;

  localparam int unsigned PRE_W = (PRESCALE > 1) ? $clog2(PRESCALE) : 1;

  logic [15:0] cps_q;

  logic       s1_valid_q;
  logic [1:0] s1_op_q;
  logic [3:0] s1_addr_q;
  logic [7:0] s1_data_q;

  logic       out_valid_q;
  logic [7:0] read_data_q, read_data_d;
  logic       sample_q, sample_d;
  logic [NUM_VOICES-1:0][3:0] level_q, level_d, mix_level;

  logic [PRE_W-1:0]  pre_q, pre_d;
  logic [PRE_W:0]    pre_inc;
  logic [15:0]       sc_q, sc_d;
  logic [16:0]       sc_inc;
  logic [15:0]       cps_eff;

  logic      out_free, proc, accept, is_tick, is_write, pre_wrap, sample_hit;
  opcode_e   op;
  reg_file_t regs;
  gen_ctrl_t gen_ctrl;
  gen_out_t  gen_out;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_CYCLES_PER_SAMPLE) ? {16'd0, cps_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cps_q <= 16'd1;
    end else if (psel && penable && pwrite && (paddr[2] == CFG_CYCLES_PER_SAMPLE)) begin
      cps_q <= pwdata[15:0];
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (proc) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= opcode_i;
      s1_addr_q <= reg_addr_i;
      s1_data_q <= write_data_i;
    end
  end

  assign op       = opcode_e'(s1_op_q);
  assign is_tick  = proc && (op == OP_TICK);
  assign is_write = proc && (op == OP_WRITE);

  tvpsg_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (is_write),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (s1_data_q),
    .regs_o    (regs)
  );

  assign pre_inc  = {1'b0, pre_q} + (PRE_W+1)'(1);
  assign pre_wrap = pre_inc >= (PRE_W+1)'(PRESCALE);
  assign pre_d    = is_tick ? (pre_wrap ? '0 : pre_inc[PRE_W-1:0]) : pre_q;

  assign cps_eff    = (cps_q == 16'd0) ? 16'd1 : cps_q;
  assign sc_inc     = {1'b0, sc_q} + 17'd1;
  assign sample_hit = sc_inc >= {1'b0, cps_eff};
  assign sc_d       = is_tick ? (sample_hit ? '0 : sc_inc[15:0]) : sc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q <= '0;
      sc_q  <= '0;
    end else begin
      pre_q <= pre_d;
      sc_q  <= sc_d;
    end
  end

  assign gen_ctrl.advance  = is_tick && pre_wrap;
  assign gen_ctrl.shape_wr = is_write && (s1_addr_q == REG_ENV_SHAPE);
  assign gen_ctrl.shape    = s1_data_q[3:0];

  tvpsg_gen u_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (gen_ctrl),
    .regs_i (regs),
    .gen_o  (gen_out)
  );

  for (genvar ch = 0; ch < NUM_VOICES; ch++) begin : g_mix
    logic tone_on, noise_on;
    logic [7:0] amp;
    assign amp      = regs[REG_AMP_A + 4'(ch)];
    assign tone_on  = regs[REG_MIXER][ch] || gen_out.tone_sign[ch];
    assign noise_on = regs[REG_MIXER][ch+3] || gen_out.noise_bit;
    assign mix_level[ch] = (tone_on && noise_on) ?
                           (amp[4] ? gen_out.env_level : amp[3:0]) : 4'd0;
  end

  always_comb begin
    read_data_d = '0;
    sample_d    = 1'b0;
    level_d     = '0;
    unique case (op)
      OP_READ: begin
        read_data_d = regs[s1_addr_q];
      end
      OP_TICK: begin
        if (sample_hit) begin
          sample_d = 1'b1;
          level_d  = mix_level;
        end
      end
      default: begin
        read_data_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      read_data_q <= read_data_d;
      sample_q    <= sample_d;
      level_q     <= level_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = read_data_q;
  assign sample_valid_o = sample_q;
  assign level_a_o      = level_q[0];
  assign level_b_o      = level_q[1];
  assign level_c_o      = level_q[2];

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result slot free");

  a_sample_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && (op != OP_TICK)) |=> !sample_valid_o)
    else $error("sample flagged for a non-tick item");

  a_read_data_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && (op != OP_READ)) |=> (read_data_o == 8'd0))
    else $error("read data on a non-read item");

  a_levels_zero_without_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !sample_valid_o) |->
      ((level_a_o == 4'd0) && (level_b_o == 4'd0) && (level_c_o == 4'd0)))
    else $error("levels driven without a sample");
`endif

endmodule

FILE: rtl/tvpsg_regs.sv
// Sixteen masked 8-bit sound registers with a single write port.
// Depends on tvpsg_pkg.
module tvpsg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [3:0]          wr_addr_i,
  input  logic [7:0]          wr_data_i,
  output tvpsg_pkg::reg_file_t regs_o
);
  import tvpsg_pkg::*;

  reg_file_t regs_q;

  function automatic logic [7:0] reg_mask(input logic [3:0] addr);
    logic [7:0] m;
    unique case (addr)
      4'd1, 4'd3, 4'd5, 4'd13:     m = 8'h0F;
      4'd6, 4'd8, 4'd9, 4'd10:     m = 8'h1F;
      default:                     m = 8'hFF;
    endcase
    return m;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '0;
    end else if (wr_en_i) begin
      regs_q[wr_addr_i] <= wr_data_i & reg_mask(wr_addr_i);
    end
  end

  assign regs_o = regs_q;

endmodule

FILE: rtl/tvpsg_gen.sv
// Tone, noise and envelope generators advanced once per prescaled tick.
// Depends on tvpsg_pkg; reports next-state values for the mixer.
module tvpsg_gen (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tvpsg_pkg::gen_ctrl_t ctrl_i,
  input  tvpsg_pkg::reg_file_t regs_i,
  output tvpsg_pkg::gen_out_t  gen_o
);
  import tvpsg_pkg::*;

  logic [NUM_VOICES-1:0][11:0] tone_count_q, tone_count_d;
  logic [NUM_VOICES-1:0]       tone_sign_q, tone_sign_d;
  logic [5:0]                  noise_count_q, noise_count_d;
  logic [16:0]                 lfsr_q, lfsr_d;
  logic [16:0]                 env_count_q, env_count_d;
  logic [4:0]                  env_step_q, env_step_d;
  logic                        env_seg_q, env_seg_d;
  logic [3:0]                  env_level_q, env_level_d;

  logic [4:0]  noise_per;
  logic [5:0]  noise_lim;
  logic [6:0]  noise_inc;
  logic [15:0] env_per;
  logic [16:0] env_lim;
  logic [17:0] env_inc;
  logic [3:0]  shape;
  logic [4:0]  step_inc;
  logic [3:0]  level_stepped;
  logic        seg_next;
  logic        hold_high;

  for (genvar ch = 0; ch < NUM_VOICES; ch++) begin : g_tone
    logic [11:0] tone_per;
    logic [12:0] tone_inc;

    always_comb begin
      tone_per = {regs_i[2*ch+1][3:0], regs_i[2*ch]};
      if (tone_per == 12'd0) begin
        tone_per = 12'd1;
      end
      tone_inc            = {1'b0, tone_count_q[ch]} + 13'd1;
      tone_count_d[ch]    = tone_count_q[ch];
      tone_sign_d[ch]     = tone_sign_q[ch];
      if (ctrl_i.advance) begin
        if (tone_inc >= {1'b0, tone_per}) begin
          tone_count_d[ch] = '0;
          tone_sign_d[ch]  = ~tone_sign_q[ch];
        end else begin
          tone_count_d[ch] = tone_inc[11:0];
        end
      end
    end
  end

  always_comb begin
    noise_per     = regs_i[REG_NOISE_PER][4:0];
    noise_lim     = (noise_per == 5'd0) ? 6'd2 : {noise_per, 1'b0};
    noise_inc     = {1'b0, noise_count_q} + 7'd1;
    noise_count_d = noise_count_q;
    lfsr_d        = lfsr_q;
    if (ctrl_i.advance) begin
      if (noise_inc >= {1'b0, noise_lim}) begin
        noise_count_d = '0;
        lfsr_d        = {lfsr_q[0] ^ lfsr_q[3], lfsr_q[16:1]};
      end else begin
        noise_count_d = noise_inc[5:0];
      end
    end
  end

  always_comb begin
    env_per   = {regs_i[REG_ENV_COARSE], regs_i[REG_ENV_FINE]};
    env_lim   = {env_per, 1'b0};
    env_inc   = {1'b0, env_count_q} + 18'd1;
    shape     = regs_i[REG_ENV_SHAPE][3:0];
    step_inc  = env_step_q + 5'd1;
    hold_high = (shape == 4'd8) || (shape == 4'd11) || (shape == 4'd13) || (shape == 4'd14);
    seg_next  = ((shape & 4'h9) == 4'h8) ? ~env_seg_q : 1'b1;

    level_stepped = env_level_q;
    if (env_step_q != 5'd0) begin
      if (env_seg_q) begin
        if ((shape == 4'd10) || (shape == 4'd12)) begin
          level_stepped = env_level_q + 4'd1;
        end else if ((shape == 4'd8) || (shape == 4'd14)) begin
          level_stepped = env_level_q - 4'd1;
        end
      end else if (shape[2]) begin
        level_stepped = env_level_q + 4'd1;
      end else begin
        level_stepped = env_level_q - 4'd1;
      end
    end

    env_count_d = env_count_q;
    env_step_d  = env_step_q;
    env_seg_d   = env_seg_q;
    env_level_d = env_level_q;
    priority if (ctrl_i.shape_wr) begin
      env_count_d = '0;
      env_seg_d   = 1'b0;
      env_step_d  = '0;
      env_level_d = ctrl_i.shape[2] ? 4'h0 : 4'hF;
    end else if (ctrl_i.advance && (env_inc >= {1'b0, env_lim})) begin
      env_count_d = '0;
      if (step_inc[4]) begin
        env_seg_d  = seg_next;
        env_step_d = '0;
        if (seg_next) begin
          env_level_d = hold_high ? 4'hF : 4'h0;
        end else begin
          env_level_d = shape[2] ? 4'h0 : 4'hF;
        end
      end else begin
        env_step_d  = step_inc;
        env_level_d = level_stepped;
      end
    end else if (ctrl_i.advance) begin
      env_count_d = env_inc[16:0];
    end else begin
      env_count_d = env_count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_count_q  <= '0;
      tone_sign_q   <= '0;
      noise_count_q <= '0;
      lfsr_q        <= 17'd1;
      env_count_q   <= '0;
      env_step_q    <= '0;
      env_seg_q     <= 1'b0;
      env_level_q   <= '0;
    end else begin
      tone_count_q  <= tone_count_d;
      tone_sign_q   <= tone_sign_d;
      noise_count_q <= noise_count_d;
      lfsr_q        <= lfsr_d;
      env_count_q   <= env_count_d;
      env_step_q    <= env_step_d;
      env_seg_q     <= env_seg_d;
      env_level_q   <= env_level_d;
    end
  end

  assign gen_o.tone_sign = tone_sign_d;
  assign gen_o.noise_bit = lfsr_d[0];
  assign gen_o.env_level = env_level_d;

endmodule

FILE: test/tb_three_voice_tone_noise_envelope_psg_unit.sv
// Testbench for three_voice_tone_noise_envelope_psg_unit: write, read, tick and unused
// items checked against an in-bench model of tone, noise and envelope generation.
// Depends on tvpsg_pkg and the top level RTL.
`timescale 1ns / 1ps

module tb_three_voice_tone_noise_envelope_psg_unit;
  import tvpsg_pkg::*;

  localparam int unsigned PSG_PRESCALE = PRESCALE_DEF;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] CPS_ADDR  = {CFG_CYCLES_PER_SAMPLE, 2'b00};

  localparam logic [3:0] REG_TONE_FINE_A   = 4'd0;
  localparam logic [3:0] REG_TONE_COARSE_A = 4'd1;
  localparam logic [3:0] REG_TONE_FINE_B   = 4'd2;
  localparam logic [3:0] REG_TONE_COARSE_B = 4'd3;
  localparam logic [3:0] REG_TONE_FINE_C   = 4'd4;
  localparam logic [3:0] REG_TONE_COARSE_C = 4'd5;
  localparam logic [3:0] REG_AMP_B         = 4'd9;
  localparam logic [3:0] REG_AMP_C         = 4'd10;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] addr;
    logic [7:0] data;
  } psg_cmd_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       smp;
    logic [3:0] lvl_a;
    logic [3:0] lvl_b;
    logic [3:0] lvl_c;
  } psg_out_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i     = '0;
  logic [3:0]  reg_addr_i   = '0;
  logic [7:0]  write_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic [7:0]  read_data_o;
  logic        sample_valid_o;
  logic [3:0]  level_a_o;
  logic [3:0]  level_b_o;
  logic [3:0]  level_c_o;

  three_voice_tone_noise_envelope_psg_unit #(
    .PRESCALE(PSG_PRESCALE)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .opcode_i(opcode_i),
    .reg_addr_i(reg_addr_i),
    .write_data_i(write_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .read_data_o(read_data_o),
    .sample_valid_o(sample_valid_o),
    .level_a_o(level_a_o),
    .level_b_o(level_b_o),
    .level_c_o(level_c_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  psg_cmd_t    psg_cmds[$];
  psg_out_t    psg_out_due[$];
  int unsigned snd_idle_pct;
  int unsigned rcv_stall_pct;
  int unsigned err_count;
  int unsigned quiet_cycles;

  logic [7:0]  sg_regs [16];
  logic [7:0]  pre_cnt;
  logic [11:0] tone_cnt [3];
  logic [2:0]  tone_sign;
  logic [5:0]  noise_cnt;
  logic [16:0] noise_sr;
  logic [16:0] env_cnt;
  logic [4:0]  env_idx;
  logic        env_seg2;
  logic [3:0]  env_lvl;
  logic [15:0] smp_cnt;
  logic [15:0] smp_period;

  function automatic logic [7:0] reg_mask(logic [3:0] a);
    case (a)
      REG_TONE_COARSE_A, REG_TONE_COARSE_B, REG_TONE_COARSE_C, REG_ENV_SHAPE: return 8'h0F;
      REG_NOISE_PER, REG_AMP_A, REG_AMP_B, REG_AMP_C: return 8'h1F;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic void psg_reset();
    for (int i = 0; i < 16; i++) sg_regs[i] = '0;
    for (int ch = 0; ch < 3; ch++) tone_cnt[ch] = '0;
    pre_cnt    = '0;
    tone_sign  = '0;
    noise_cnt  = '0;
    noise_sr   = 17'd1;
    env_cnt    = '0;
    env_idx    = '0;
    env_seg2   = 1'b0;
    env_lvl    = '0;
    smp_cnt    = '0;
    smp_period = 16'd1;
  endfunction

  function automatic void env_reload();
    logic [3:0] shape;
    shape = sg_regs[REG_ENV_SHAPE][3:0];
    env_idx = '0;
    if (env_seg2) begin
      env_lvl = (shape == 4'd8 || shape == 4'd11 || shape == 4'd13 || shape == 4'd14) ?
                4'hF : 4'h0;
    end else begin
      env_lvl = shape[2] ? 4'h0 : 4'hF;
    end
  endfunction

  function automatic void gen_advance();
    int unsigned per;
    int unsigned cnt;
    logic [3:0]  shape;
    shape = sg_regs[REG_ENV_SHAPE][3:0];
    for (int ch = 0; ch < 3; ch++) begin
      per = {sg_regs[2*ch+1], sg_regs[2*ch]};
      if (per == 0) per = 1;
      cnt = tone_cnt[ch] + 1;
      if (cnt >= per) begin
        tone_cnt[ch]  = '0;
        tone_sign[ch] = ~tone_sign[ch];
      end else begin
        tone_cnt[ch] = 12'(cnt);
      end
    end
    per = sg_regs[REG_NOISE_PER];
    if (per == 0) per = 1;
    cnt = noise_cnt + 1;
    if (cnt >= 2 * per) begin
      noise_cnt = '0;
      noise_sr  = {noise_sr[0] ^ noise_sr[3], noise_sr[16:1]};
    end else begin
      noise_cnt = 6'(cnt);
    end
    per = {sg_regs[REG_ENV_COARSE], sg_regs[REG_ENV_FINE]};
    cnt = env_cnt + 1;
    if (cnt >= 2 * per) begin
      env_cnt = '0;
      if (env_idx != 0) begin
        if (env_seg2) begin
          if (shape == 4'd10 || shape == 4'd12) env_lvl = env_lvl + 4'd1;
          else if (shape == 4'd8 || shape == 4'd14) env_lvl = env_lvl - 4'd1;
        end else if (shape[2]) begin
          env_lvl = env_lvl + 4'd1;
        end else begin
          env_lvl = env_lvl - 4'd1;
        end
      end
      env_idx = env_idx + 5'd1;
      if (env_idx >= 5'd16) begin
        if (shape[3] && !shape[0]) env_seg2 = ~env_seg2;
        else env_seg2 = 1'b1;
        env_reload();
      end
    end else begin
      env_cnt = 17'(cnt);
    end
  endfunction

  function automatic psg_out_t psg_apply(psg_cmd_t c);
    psg_out_t    r;
    logic [3:0]  lvl [3];
    logic [7:0]  amp;
    int unsigned per;
    r = '0;
    case (c.opcode)
      OP_WRITE: begin
        sg_regs[c.addr] = c.data & reg_mask(c.addr);
        if (c.addr == REG_ENV_SHAPE) begin
          env_cnt  = '0;
          env_seg2 = 1'b0;
          env_reload();
        end
      end
      OP_READ: r.rdata = sg_regs[c.addr];
      OP_TICK: begin
        per = (smp_period == 0) ? 1 : smp_period;
        if (pre_cnt + 1 >= PSG_PRESCALE) begin
          pre_cnt = '0;
          gen_advance();
        end else begin
          pre_cnt = pre_cnt + 8'd1;
        end
        if (smp_cnt + 1 >= per) begin
          smp_cnt = '0;
          r.smp   = 1'b1;
          for (int ch = 0; ch < 3; ch++) begin
            amp = sg_regs[REG_AMP_A + ch];
            lvl[ch] = 4'h0;
            if ((sg_regs[REG_MIXER][ch] | tone_sign[ch]) &&
                (sg_regs[REG_MIXER][ch+3] | noise_sr[0])) begin
              lvl[ch] = amp[4] ? env_lvl : amp[3:0];
            end
          end
          r.lvl_a = lvl[0];
          r.lvl_b = lvl[1];
          r.lvl_c = lvl[2];
        end else begin
          smp_cnt = smp_cnt + 16'd1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic psg_cmd_t psg_rand_cmd();
    psg_cmd_t    c;
    int unsigned pick;
    pick   = $urandom_range(99);
    c.addr = 4'($urandom_range(15));
    c.data = 8'($urandom_range(255));
    if (pick < 80) begin
      c.opcode = OP_TICK;
    end else if (pick < 92) begin
      c.opcode = OP_WRITE;
      // keep envelope restarts rare so the shape sequencer gets through its segments
      if (c.addr == REG_ENV_SHAPE && $urandom_range(5) != 0) c.addr = REG_MIXER;
      if ($urandom_range(7) != 0) begin
        case (c.addr)
          REG_TONE_FINE_A, REG_TONE_FINE_B, REG_TONE_FINE_C: c.data = 8'($urandom_range(6));
          REG_TONE_COARSE_A, REG_TONE_COARSE_B, REG_TONE_COARSE_C: c.data = 8'h00;
          REG_NOISE_PER: c.data = 8'($urandom_range(4));
          REG_ENV_FINE: c.data = ($urandom_range(3) == 0) ? 8'h01 : 8'h00;
          REG_ENV_COARSE: c.data = 8'h00;
          default: ;
        endcase
      end
    end else if (pick < 98) begin
      c.opcode = OP_READ;
    end else begin
      c.opcode = OP_UNUSED;
    end
    return c;
  endfunction

  function automatic void note_fail(string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endfunction

  task automatic add_cmd(input logic [1:0] op, input logic [3:0] addr, input logic [7:0] data);
    psg_cmd_t c;
    c.opcode = op;
    c.addr   = addr;
    c.data   = data;
    psg_cmds.push_back(c);
  endtask

  task automatic wait_drained();
    while (psg_cmds.size() != 0 || in_valid_i || psg_out_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [15:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'h0000, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    smp_period = value;
  endtask

  task automatic run_segment(input logic [15:0] period, input int n,
                             input int unsigned snd_pct, input int unsigned rcv_pct);
    wait_drained();
    cfg_write(CPS_ADDR, period);
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    @(negedge clk_i);
    add_cmd(OP_WRITE, REG_ENV_FINE, 8'h00);
    add_cmd(OP_WRITE, REG_ENV_COARSE, 8'h00);
    add_cmd(OP_WRITE, REG_ENV_SHAPE, 8'($urandom_range(15)));
    repeat (n) psg_cmds.push_back(psg_rand_cmd());
  endtask

  always @(posedge clk_i) begin : cmd_drive
    psg_cmd_t c;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        c.opcode = opcode_i;
        c.addr   = reg_addr_i;
        c.data   = write_data_i;
        psg_out_due.push_back(psg_apply(c));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (psg_cmds.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          c = psg_cmds.pop_front();
          in_valid_i   <= 1'b1;
          opcode_i     <= c.opcode;
          reg_addr_i   <= c.addr;
          write_data_i <= c.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : out_check
    psg_out_t got;
    psg_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.rdata = read_data_o;
        got.smp   = sample_valid_o;
        got.lvl_a = level_a_o;
        got.lvl_b = level_b_o;
        got.lvl_c = level_c_o;
        if (psg_out_due.size() == 0) begin
          note_fail($sformatf("unexpected item: read_data %0h sample_valid %0b levels %0h/%0h/%0h",
                              got.rdata, got.smp, got.lvl_a, got.lvl_b, got.lvl_c));
        end else begin
          want = psg_out_due.pop_front();
          if (got !== want) begin
            note_fail($sformatf({"mismatch: read_data exp %0h got %0h, sample_valid exp %0b got %0b,",
                                 " levels exp %0h/%0h/%0h got %0h/%0h/%0h"},
                                want.rdata, got.rdata, want.smp, got.smp,
                                want.lvl_a, want.lvl_b, want.lvl_c,
                                got.lvl_a, got.lvl_b, got.lvl_c));
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    err_count     = 0;
    quiet_cycles  = 0;
    snd_idle_pct  = 24;
    rcv_stall_pct = 78;
    psg_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    add_cmd(OP_READ, REG_ENV_SHAPE, 8'h00);
    add_cmd(OP_TICK, 4'd0, 8'h00);
    add_cmd(OP_TICK, 4'd15, 8'hFF);
    add_cmd(OP_WRITE, REG_TONE_FINE_A, 8'hFF);
    add_cmd(OP_WRITE, REG_TONE_COARSE_A, 8'hFF);
    add_cmd(OP_READ, REG_TONE_COARSE_A, 8'h00);
    add_cmd(OP_WRITE, REG_MIXER, 8'hFF);
    add_cmd(OP_WRITE, REG_AMP_A, 8'hFF);
    add_cmd(OP_WRITE, REG_AMP_B, 8'h0F);
    add_cmd(OP_WRITE, REG_AMP_C, 8'h00);
    add_cmd(OP_WRITE, REG_ENV_FINE, 8'h00);
    add_cmd(OP_WRITE, REG_ENV_COARSE, 8'h00);
    add_cmd(OP_WRITE, REG_ENV_SHAPE, 8'hFF);
    add_cmd(OP_READ, REG_AMP_A, 8'h00);
    add_cmd(OP_READ, REG_ENV_SHAPE, 8'h00);
    add_cmd(OP_UNUSED, 4'd15, 8'hFF);
    add_cmd(OP_WRITE, REG_NOISE_PER, 8'hFF);
    add_cmd(OP_READ, REG_NOISE_PER, 8'h00);
    repeat (6) add_cmd(OP_TICK, 4'd0, 8'h00);

    run_segment(16'd0, 300, 24, 78);
    run_segment(16'd300, 200, 24, 78);
    run_segment(16'd2, 250, 78, 24);
    run_segment(16'hFFFF, 150, 78, 24);
    run_segment(16'd5, 550, 0, 0);
    run_segment(16'd1, 260, 0, 0);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (err_count == 0 && psg_out_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/tvpsg_pkg.sv
rtl/tvpsg_regs.sv
rtl/tvpsg_gen.sv
rtl/three_voice_tone_noise_envelope_psg_unit.sv
test/tb_three_voice_tone_noise_envelope_psg_unit.sv
